@@ hw/rtl/mpwq_pkg.sv @@
// Shared constants and types for the min-priority work queue.
`default_nettype none

package mpwq_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned DefDepth    = 32;
  localparam int unsigned DefTagBits  = 16;
  localparam int unsigned DefPrioBits = 32;

  // Operation codes on the request channel
  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_POP   = 2'd1,
    FN_FLUSH = 2'd2
  } func_e;

  // Status flags of one response beat
  typedef struct packed {
    logic found;
    logic dropped;
  } res_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/mpwq_req_if.sv @@
// Request channel: operation, tag and priority with valid/ready handshake.
`default_nettype none

interface mpwq_req_if
  import mpwq_pkg::*;
#(
  parameter int unsigned TAG_BITS  = DefTagBits,
  parameter int unsigned PRIO_BITS = DefPrioBits
) ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [TAG_BITS-1:0]         handle_tag;
  logic signed [PRIO_BITS-1:0] prio_value;

  modport source (output valid, output func, output handle_tag, output prio_value,
                  input ready);
  modport sink   (input valid, input func, input handle_tag, input prio_value,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mpwq_rsp_if.sv @@
// Response channel: popped tag, status flags and fill count with valid/ready handshake.
`default_nettype none

interface mpwq_rsp_if
  import mpwq_pkg::*;
#(
  parameter int unsigned DEPTH    = DefDepth,
  parameter int unsigned TAG_BITS = DefTagBits
) ();
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                valid;
  logic                ready;
  logic [TAG_BITS-1:0] popped_tag;
  logic                found;
  logic                dropped;
  logic [CntW-1:0]     fill_count;

  modport source (output valid, output popped_tag, output found, output dropped,
                  output fill_count, input ready);
  modport sink   (input valid, input popped_tag, input found, input dropped,
                  input fill_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mpwq_mem.sv @@
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module mpwq_mem
  import mpwq_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth,
  parameter int unsigned WIDTH = DefTagBits + DefPrioBits
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mpwq_ctrl.sv @@
// Sequencer: append, min-scan over the store, compaction and flush.
`default_nettype none

module mpwq_ctrl
  import mpwq_pkg::*;
#(
  parameter int unsigned DEPTH     = DefDepth,
  parameter int unsigned TAG_BITS  = DefTagBits,
  parameter int unsigned PRIO_BITS = DefPrioBits,
  localparam int unsigned IdxW     = $clog2(DEPTH),
  localparam int unsigned CntW     = $clog2(DEPTH + 1),
  localparam int unsigned WordW    = TAG_BITS + PRIO_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  mpwq_req_if.sink                  req_i,
  // memory port
  output logic                      mem_we_o,
  output logic [IdxW-1:0]           mem_waddr_o,
  output logic [WordW-1:0]          mem_wdata_o,
  output logic                      mem_re_o,
  output logic [IdxW-1:0]           mem_raddr_o,
  input  wire logic [WordW-1:0]     mem_rdata_i,
  // result toward the output register
  output logic                      res_valid_o,
  input  wire logic                 res_take_i,
  output logic [TAG_BITS-1:0]       res_tag_o,
  output res_flags_t                res_flags_o,
  output logic [CntW-1:0]           res_count_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_RESP  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     ptr_q, ptr_d;
  logic                pend_q, pend_d;
  logic                have_q, have_d;
  logic [IdxW-1:0]     pend_idx_q, pend_idx_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  logic [PRIO_BITS-1:0] best_key_q, best_key_d;
  logic [TAG_BITS-1:0] best_tag_q, best_tag_d;
  logic [TAG_BITS-1:0] res_tag_q, res_tag_d;
  res_flags_t          res_flags_q, res_flags_d;

  logic [PRIO_BITS-1:0] rd_prio;
  logic [TAG_BITS-1:0]  rd_tag;
  logic [PRIO_BITS-1:0] rd_key;
  logic                 better;
  logic                 more;
  logic                 accept;

  // Split the returned word and map the signed priority to an unsigned order key
  assign rd_prio = mem_rdata_i[PRIO_BITS-1:0];
  assign rd_tag  = mem_rdata_i[WordW-1:PRIO_BITS];
  assign rd_key  = {~rd_prio[PRIO_BITS-1], rd_prio[PRIO_BITS-2:0]};
  // Strict less-than keeps the earliest entry on ties and never picks infinity
  assign better  = pend_q && (rd_key < best_key_q);
  assign more    = ptr_q < cnt_q;
  assign accept  = req_i.valid && req_i.ready;

  assign req_i.ready = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_tag_o   = res_tag_q;
  assign res_flags_o = res_flags_q;
  assign res_count_o = cnt_q;

  // Next-state and memory access logic
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    have_d      = have_q;
    best_idx_d  = best_idx_q;
    best_key_d  = best_key_q;
    best_tag_d  = best_tag_q;
    res_tag_d   = res_tag_q;
    res_flags_d = res_flags_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[IdxW-1:0];
    mem_wdata_o = {req_i.handle_tag, req_i.prio_value};
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q[IdxW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          res_tag_d   = '0;
          res_flags_d = '0;
          state_d     = ST_RESP;
          unique case (func_e'(req_i.func))
            FN_ADD: begin
              if (cnt_q == CntW'(DEPTH)) begin
                res_flags_d.dropped = 1'b1;
              end else begin
                mem_we_o = 1'b1;
                cnt_d    = cnt_q + CntW'(1);
              end
            end
            FN_POP: begin
              if (cnt_q != '0) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                ptr_d       = CntW'(1);
                pend_d      = 1'b1;
                pend_idx_d  = '0;
                have_d      = 1'b0;
                best_key_d  = '1;
                state_d     = ST_SCAN;
              end
            end
            FN_FLUSH: begin
              cnt_d = '0;
            end
            default: begin
              cnt_d = cnt_q;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous beat is compared
        if (more) begin
          mem_re_o   = 1'b1;
          ptr_d      = ptr_q + CntW'(1);
          pend_d     = 1'b1;
          pend_idx_d = ptr_q[IdxW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (better) begin
          best_key_d = rd_key;
          best_idx_d = pend_idx_q;
          best_tag_d = rd_tag;
          have_d     = 1'b1;
        end
        // Last entry compared: remove the winner or report not found
        if (!more) begin
          if (have_d) begin
            res_tag_d         = best_tag_d;
            res_flags_d.found = 1'b1;
            ptr_d             = CntW'(best_idx_d) + CntW'(1);
            state_d           = ST_SHIFT;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      ST_SHIFT: begin
        // Move each later entry down by one slot
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pend_idx_q - IdxW'(1);
          mem_wdata_o = mem_rdata_i;
        end
        if (more) begin
          mem_re_o   = 1'b1;
          ptr_d      = ptr_q + CntW'(1);
          pend_d     = 1'b1;
          pend_idx_d = ptr_q[IdxW-1:0];
        end else begin
          pend_d  = 1'b0;
          cnt_d   = cnt_q - CntW'(1);
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      have_q  <= have_d;
    end
  end

  // Scan bookkeeping and result payload
  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    pend_idx_q  <= pend_idx_d;
    best_idx_q  <= best_idx_d;
    best_key_q  <= best_key_d;
    best_tag_q  <= best_tag_d;
    res_tag_q   <= res_tag_d;
    res_flags_q <= res_flags_d;
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write hit the same entry");

  a_shift_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && pend_q) |-> (pend_idx_q != '0))
    else $error("compaction writes below slot zero");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_flags_q.found && res_flags_q.dropped))
    else $error("found and dropped both set");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.func == FN_POP && cnt_q == '0) |=> (state_q == ST_RESP))
    else $error("pop on empty store did not answer at once");

endmodule

`default_nettype wire

@@ hw/rtl/min_priority_work_queue.sv @@
// Min-priority work queue: top level with sequencer, entry store and output register.
// Add, flush: the request is accepted in ST_IDLE, then the beat waits in ST_RESP until the output register takes it.
// Pop over n held entries removing slot j: all n are scanned, then n - j - 1 are moved,
//   through the one read port of the store (one scanned, then one moved, per cycle).
// A new request is taken while the previous response beat waits in the output register.
// Reset clears the entry count and the handshake state; entry contents stay undefined.
`default_nettype none

module min_priority_work_queue
  import mpwq_pkg::*;
#(
  parameter int unsigned DEPTH     = DefDepth,
  parameter int unsigned TAG_BITS  = DefTagBits,
  parameter int unsigned PRIO_BITS = DefPrioBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mpwq_req_if.sink  req_i,
  mpwq_rsp_if.source rsp_o
);

  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned WordW = TAG_BITS + PRIO_BITS;

  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  logic [WordW-1:0]    mem_wdata;
  logic                mem_re;
  logic [IdxW-1:0]     mem_raddr;
  logic [WordW-1:0]    mem_rdata;

  logic                res_valid;
  logic                res_take;
  logic [TAG_BITS-1:0] res_tag;
  res_flags_t          res_flags;
  logic [CntW-1:0]     res_count;

  logic                out_valid_q;
  logic [TAG_BITS-1:0] out_tag_q;
  res_flags_t          out_flags_q;
  logic [CntW-1:0]     out_count_q;

  mpwq_ctrl #(
    .DEPTH     (DEPTH),
    .TAG_BITS  (TAG_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_tag_o   (res_tag),
    .res_flags_o (res_flags),
    .res_count_o (res_count)
  );

  mpwq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WordW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Load the output register when it is empty or its beat leaves this cycle
  assign res_take = res_valid && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the response payload
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_tag_q   <= res_tag;
      out_flags_q <= res_flags;
      out_count_q <= res_count;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.popped_tag = out_tag_q;
  assign rsp_o.found      = out_flags_q.found;
  assign rsp_o.dropped    = out_flags_q.dropped;
  assign rsp_o.fill_count = out_count_q;

endmodule

`default_nettype wire
